// ===== src/jdc_pkg.sv =====
// ----------------------------------------------------------------------------
// jdc_pkg: shared types and constants for the day number to date converter
// Constant divisors are applied as reciprocal multiplies followed by a single
// compare-and-subtract correction step.
// ----------------------------------------------------------------------------
package jdc_pkg;

  // Field widths
  localparam int JD_W    = 23;  // day number in
  localparam int A_W     = 26;  // quarter-day scaled day count
  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int NUM_W   = 12;  // 10*d0+5, at most 3655

  // Stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Gregorian switch-over and correction
  localparam logic [JD_W-1:0] GREG_START = 23'd2299161;
  localparam logic [A_W-1:0]  GREG_OFS   = 26'd17918;
  localparam logic [26:0]     GREG_DIV   = 27'd146097;
  localparam logic [8:0]      GREG_RCP   = 9'd459;      // floor(2^26/146097)
  localparam logic [8:0]      GREG_BIAS  = 9'd37;
  localparam int              RCP_SHIFT  = 26;

  // Year split, scaled by 4 (1461 quarter days to a year)
  localparam logic [A_W-1:0]  MAR_OFS    = 26'd1224;    // 1461 - 237
  localparam logic [A_W-1:0]  YEAR_DIV   = 26'd1461;
  localparam logic [15:0]     YEAR_RCP   = 16'd45933;   // floor(2^26/1461)
  localparam logic signed [YEAR_W-1:0] EPOCH_YEAR = 16'sd4712;

  // Month split, scaled by 10 (306 tenths per 30.6 day month)
  localparam logic [NUM_W-1:0] MON_DIV   = 12'd306;
  localparam logic [7:0]       MON_RCP   = 8'd214;      // floor(2^16/306)
  localparam int               MON_SHIFT = 16;
  localparam logic [8:0]       DAY_RCP   = 9'd409;      // floor(2^12/10)
  localparam int               DAY_SHIFT = 12;

  // Request passed from the year stage to the month/day stage
  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic [NUM_W-1:0]         num;
    logic [3:0]               t_est;
  } year_item_t;

endpackage

// ===== src/julian_day_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date: Julian Day Number to calendar date
// Nine-stage pipeline converting a day number to year, month and day.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one request per day number, tdata[22:0] holds it.
//   Output stream m_axis_*: one result per request, in order:
//     tdata[15:0] year (two's complement, 1 BC is -1), [19:16] month,
//     [24:20] day of month, upper bits zero.
//   Day numbers from 2299161 on follow the Gregorian calendar, earlier ones
//   the Julian calendar.
// Throughput: one request per cycle while m_axis_tready is high, set by the
//   nine register stages; each stage holds at most one reciprocal multiply
//   and one correction compare.
// Reset: rst (synchronous, active high) drops all stage valid bits; the
//   pipeline comes up empty and s_axis_tready is high.
// Stall: each stage has its own ready, so bubbles close up while
//   m_axis_tready is low; once all nine stages are full s_axis_tready drops.
//   Held results stay on m_axis_tdata until taken. No state between requests.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [jdc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [22:0] julian_day
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [jdc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // year, month, day
);

  logic                          g_valid, g_ready;
  logic [jdc_pkg::A_W-1:0]       g_a;
  logic                          y_valid, y_ready;
  jdc_pkg::year_item_t           y_item;
  logic [jdc_pkg::YEAR_W-1:0]    year;
  logic [jdc_pkg::MONTH_W-1:0]   month;
  logic [jdc_pkg::DAY_W-1:0]     day;

  // Gregorian correction and March shift
  jdc_greg u_greg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .julian_day (s_axis_tdata[jdc_pkg::JD_W-1:0]),
    .out_valid  (g_valid),
    .out_ready  (g_ready),
    .a_out      (g_a)
  );

  // Year split
  jdc_year u_year (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .a_in      (g_a),
    .out_valid (y_valid),
    .out_ready (y_ready),
    .item_out  (y_item)
  );

  // Month and day split, output register
  jdc_mdy u_mdy (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (y_valid),
    .in_ready  (y_ready),
    .item_in   (y_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .year      (year),
    .month     (month),
    .day       (day)
  );

  // Pack result, lowest field first
  assign m_axis_tdata = {7'd0, day, month, year};

  // Results always carry a month of 1 to 12, a nonzero day and no year zero
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[19:16] >= 4'd1 && m_axis_tdata[19:16] <= 4'd12))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[24:20] >= 5'd1))
    else $error("day of month is zero");

  a_no_year_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:0] != 16'd0))
    else $error("year zero produced");

  // An empty output stage means no stage can be blocking the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

endmodule

// ===== src/jdc_greg.sv =====
// ----------------------------------------------------------------------------
// jdc_greg: Gregorian correction front end
// Three stages: estimate the 400-year cycle count, correct it, then form the
// corrected day number scaled by four and offset to a March-based year.
// ----------------------------------------------------------------------------
module jdc_greg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [jdc_pkg::JD_W-1:0]     julian_day,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [jdc_pkg::A_W-1:0]      a_out
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  logic [jdc_pkg::JD_W-1:0] j1, j2;
  logic                     greg1, greg2;
  logic [jdc_pkg::A_W-1:0]  b1;
  logic [8:0]               qe1, q2;
  logic [jdc_pkg::A_W-1:0]  a3;

  // Stage ready chain, bubbles collapse
  assign rdy3      = !v3 || out_ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v3;
  assign a_out     = a3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Stage 1: cycle count estimate, may be one low
  logic [jdc_pkg::A_W-1:0] b_in;
  logic [34:0]             prod1;
  assign b_in  = {julian_day, 2'b00} - jdc_pkg::GREG_OFS;
  assign prod1 = 35'(b_in) * 35'(jdc_pkg::GREG_RCP);

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      j1    <= julian_day;
      greg1 <= julian_day >= jdc_pkg::GREG_START;
      b1    <= b_in;
      qe1   <= prod1[34:jdc_pkg::RCP_SHIFT];
    end
  end

  // Stage 2: remainder check fixes the estimate
  logic [26:0] prodq, rem2;
  logic [8:0]  q_next;
  assign prodq  = 27'(qe1) * jdc_pkg::GREG_DIV;
  assign rem2   = {1'b0, b1} - prodq;
  assign q_next = (rem2 >= jdc_pkg::GREG_DIV) ? qe1 + 9'd1 : qe1;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      j2    <= j1;
      greg2 <= greg1;
      q2    <= q_next;
    end
  end

  // Stage 3: apply correction, scale by four, shift to March
  logic [10:0]             c3;
  logic [8:0]              corr;
  logic [jdc_pkg::JD_W:0]  jp;
  logic [jdc_pkg::A_W-1:0] a_next;
  assign c3     = 11'(q2) * 11'd3 + 11'd2;
  assign corr   = 9'(c3 >> 2) - jdc_pkg::GREG_BIAS;
  assign jp     = {1'b0, j2} + (greg2 ? 24'(corr) : 24'd0);
  assign a_next = {jp, 2'b00} + jdc_pkg::MAR_OFS;

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      a3 <= a_next;
    end
  end

endmodule

// ===== src/jdc_year.sv =====
// ----------------------------------------------------------------------------
// jdc_year: year split
// Three stages: divide the scaled day count by 1461 by reciprocal, correct the
// quotient, then form the signed year, the month numerator and its estimate.
// ----------------------------------------------------------------------------
module jdc_year (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [jdc_pkg::A_W-1:0]     a_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output jdc_pkg::year_item_t         item_out
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  logic [jdc_pkg::A_W-1:0] a1;
  logic [15:0]             qe1;
  logic [14:0]             qa2;
  logic [10:0]             r2;
  jdc_pkg::year_item_t     item3;

  assign rdy3      = !v3 || out_ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v3;
  assign item_out  = item3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Stage 1: quotient estimate, at most one low
  logic [41:0] prod1;
  assign prod1 = 42'(a_in) * 42'(jdc_pkg::YEAR_RCP);

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      a1  <= a_in;
      qe1 <= prod1[41:jdc_pkg::RCP_SHIFT];
    end
  end

  // Stage 2: correct quotient, keep remainder (day of March year, x4)
  logic [jdc_pkg::A_W-1:0] r_est;
  logic                    bump;
  assign r_est = a1 - 26'(qe1) * jdc_pkg::YEAR_DIV;
  assign bump  = r_est >= jdc_pkg::YEAR_DIV;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      qa2 <= bump ? 15'(qe1 + 16'd1) : qe1[14:0];
      r2  <= bump ? 11'(r_est - jdc_pkg::YEAR_DIV) : r_est[10:0];
    end
  end

  // Stage 3: signed year with no year zero, month numerator and estimate
  logic [14:0]                      yq;
  logic signed [jdc_pkg::YEAR_W-1:0] y_raw;
  logic [8:0]                       d0;
  logic [jdc_pkg::NUM_W-1:0]        num;
  logic [19:0]                      prod3;
  jdc_pkg::year_item_t              item_next;

  assign yq    = (r2 >= 11'(jdc_pkg::MAR_OFS)) ? qa2 : qa2 - 15'd1;
  assign y_raw = signed'({1'b0, yq}) - jdc_pkg::EPOCH_YEAR;
  assign d0    = r2[10:2];
  assign num   = 12'(d0) * 12'd10 + 12'd5;
  assign prod3 = 20'(num) * 20'(jdc_pkg::MON_RCP);

  always_comb begin
    item_next.year  = (y_raw <= 16'sd0) ? y_raw - 16'sd1 : y_raw;
    item_next.num   = num;
    item_next.t_est = prod3[19:jdc_pkg::MON_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      item3 <= item_next;
    end
  end

endmodule

// ===== src/jdc_mdy.sv =====
// ----------------------------------------------------------------------------
// jdc_mdy: month and day split
// Three stages: correct the month quotient, map it to a calendar month and
// estimate the day, then correct the day and register the result.
// ----------------------------------------------------------------------------
module jdc_mdy (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  jdc_pkg::year_item_t            item_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [jdc_pkg::YEAR_W-1:0]     year,
  output logic [jdc_pkg::MONTH_W-1:0]    month,
  output logic [jdc_pkg::DAY_W-1:0]      day
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  logic [jdc_pkg::YEAR_W-1:0]  y1, y2, y3;
  logic [3:0]                  t1;
  logic [8:0]                  rem1, rem2;
  logic [jdc_pkg::MONTH_W-1:0] m2, m3;
  logic [5:0]                  de2;
  logic [jdc_pkg::DAY_W-1:0]   d3;

  assign rdy3      = !v3 || out_ready;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v3;
  assign year      = y3;
  assign month     = m3;
  assign day       = d3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Stage 1: month quotient correction
  logic [jdc_pkg::NUM_W-1:0] rem_est;
  logic                      bump;
  assign rem_est = item_in.num - 12'(item_in.t_est) * jdc_pkg::MON_DIV;
  assign bump    = rem_est >= jdc_pkg::MON_DIV;

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      y1   <= item_in.year;
      t1   <= bump ? item_in.t_est + 4'd1 : item_in.t_est;
      rem1 <= bump ? 9'(rem_est - jdc_pkg::MON_DIV) : rem_est[8:0];
    end
  end

  // Stage 2: March-based index to calendar month, day estimate
  logic [17:0] prod2;
  assign prod2 = 18'(rem1) * 18'(jdc_pkg::DAY_RCP);

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      y2   <= y1;
      m2   <= (t1 <= 4'd9) ? t1 + 4'd3 : t1 - 4'd9;
      rem2 <= rem1;
      de2  <= prod2[17:jdc_pkg::DAY_SHIFT];
    end
  end

  // Stage 3: day correction, result register
  logic [8:0] drem;
  assign drem = rem2 - 9'(de2) * 9'd10;

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      y3 <= y2;
      m3 <= m2;
      d3 <= 5'(de2) + ((drem >= 9'd10) ? 5'd2 : 5'd1);
    end
  end

endmodule

// ===== sim/julian_day_to_calendar_date_test.sv =====
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date_test: self-checking bench for the date converter
// Drives day numbers into the input stream and compares every output date
// against dates worked out in the bench with exact integer arithmetic.
// Covers the Julian/Gregorian switch-over, the years around 1 BC / 1 AD, the
// low day numbers where the March-based year wraps, and the full input range.
// Both stream sides idle at random; one long output stall fills the
// pipeline, and the sender pauses more than once until every date has come back.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date_test;

  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_CYCLES  = 80;

  // Calendar constants, days and quarter days
  localparam int unsigned GREGORIAN_FIRST = 2299161;
  localparam int unsigned QUAD_YEAR       = 1461;
  localparam int unsigned MARCH_SHIFT     = 237;
  localparam int unsigned MONTH_TENTHS    = 306;
  localparam int          EPOCH_OFFSET    = 4712;
  localparam int unsigned JULIAN_AD1      = 1721424;

  // Day numbers at the edges of the calendar logic
  localparam logic [jdc_pkg::JD_W-1:0] EDGE_DAYS [24] = '{
    23'd0, 23'd1, 23'd59, 23'd60, 23'd61, 23'd365,
    23'd1721057, 23'd1721058, 23'd1721423, 23'd1721424,
    23'd2299159, 23'd2299160, 23'd2299161, 23'd2299162,
    23'd2361221, 23'd2415079, 23'd2451604, 23'd2451605, 23'd2451910,
    23'd4194304, 23'h2AAAAA, 23'h555555, 23'd8388606, 23'd8388607
  };

  // Scoreboard: dates owed by the block, oldest first
  class date_scoreboard;
    typedef struct packed {
      logic [jdc_pkg::JD_W-1:0]          jd;
      logic signed [jdc_pkg::YEAR_W-1:0] year;
      logic [jdc_pkg::MONTH_W-1:0]       month;
      logic [jdc_pkg::DAY_W-1:0]         day;
    } owed_date_t;

    owed_date_t owed[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    task report(input string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    // Work out the calendar date for one accepted day number
    function void note_request(input logic [jdc_pkg::JD_W-1:0] jd);
      int unsigned j, adj, cycles, qpos, doy, tenths, mon_idx;
      int          yr;
      owed_date_t  d;
      j   = jd;
      adj = j;
      // Gregorian correction for dropped century leap days
      if (j >= GREGORIAN_FIRST) begin
        cycles = (4 * j - 17918) / 146097;
        adj    = j + (3 * cycles + 2) / 4 - 37;
      end
      yr = int'((4 * adj) / QUAD_YEAR) - EPOCH_OFFSET;
      // position in a March-based year, kept non-negative
      qpos    = (4 * adj + QUAD_YEAR - MARCH_SHIFT) % QUAD_YEAR;
      doy     = qpos / 4;
      tenths  = 10 * doy + 5;
      mon_idx = tenths / MONTH_TENTHS;
      // no year zero
      if (yr <= 0) yr = yr - 1;
      d.jd    = jd;
      d.year  = yr[jdc_pkg::YEAR_W-1:0];
      d.month = jdc_pkg::MONTH_W'((mon_idx + 2) % 12 + 1);
      d.day   = jdc_pkg::DAY_W'((tenths % MONTH_TENTHS) / 10 + 1);
      owed.push_back(d);
    endfunction

    // Compare one output date with the oldest owed one
    task check_result(input logic [jdc_pkg::OUT_TDATA_W-1:0] tdata);
      owed_date_t d;
      if (owed.size() == 0) begin
        report($sformatf("date %h arrived with no request outstanding", tdata));
      end else begin
        d = owed.pop_front();
        if ($signed(tdata[15:0]) !== d.year)
          report($sformatf("day %0d: year %0d, want %0d", d.jd,
                           $signed(tdata[15:0]), d.year));
        if (tdata[19:16] !== d.month)
          report($sformatf("day %0d: month %0d, want %0d", d.jd, tdata[19:16], d.month));
        if (tdata[24:20] !== d.day)
          report($sformatf("day %0d: day %0d, want %0d", d.jd, tdata[24:20], d.day));
        if (tdata[jdc_pkg::OUT_TDATA_W-1:25] !== '0)
          report($sformatf("day %0d: pad bits %h not zero", d.jd,
                           tdata[jdc_pkg::OUT_TDATA_W-1:25]));
      end
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [jdc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;  // [22:0] julian_day
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [15:0] year, [19:16] month, [24:20] day
  logic [jdc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  bit steady   = 1'b0;  // neither side idles
  bit hold_req = 1'b0;  // asks the receiver for a long stall

  date_scoreboard book = new();

  julian_day_to_calendar_date DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one day number, optionally after random idle cycles
  task automatic send_day(input logic [jdc_pkg::JD_W-1:0] jd, input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 33) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, jd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    book.note_request(jd);
  endtask

  // Stop sending until every owed date has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (book.owed.size() != 0);
  endtask

  // Output side: check taken dates, then pick ready for the next cycle
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tdata);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 33);
      end
    end
  end

  // Input side: edge days, then random day numbers
  initial begin : stimulus
    logic [jdc_pkg::JD_W-1:0] jd;
    int                       pick;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (EDGE_DAYS[k]) send_day(EDGE_DAYS[k], 1'b1);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // long output stall while the sender keeps pushing
      if (i == 400) hold_req = 1'b1;
      steady = (i >= 800 && i < 1100);
      if (i == 1200) wait_drained();
      pick = $urandom_range(99);
      if (pick < 45)
        jd = jdc_pkg::JD_W'($urandom_range(8388607));
      else if (pick < 70)
        jd = jdc_pkg::JD_W'(GREGORIAN_FIRST - 2000 + $urandom_range(3999));
      else if (pick < 85)
        jd = jdc_pkg::JD_W'(JULIAN_AD1 - 1000 + $urandom_range(1999));
      else
        jd = jdc_pkg::JD_W'($urandom_range(3000));
      send_day(jd, !(steady || (i >= 400 && i < 480)));
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (book.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
